/* rtl/sva_pkg.sv */
// ----------------------------------------------------------------------------
// Sampler voice allocator package
// Shared sizes, request and status codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sva_pkg;

  // Pool and table sizes.
  localparam int PLAYERS = 32;
  localparam int REGIONS = 64;

  // Counter and index widths derived from the sizes.
  localparam int PCW = $clog2(PLAYERS + 1);
  localparam int PIW = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
  localparam int RCW = $clog2(REGIONS + 1);
  localparam int RIW = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  // Field widths of the input and result words.
  localparam int REQ_W    = 2;
  localparam int KEY_W    = 7;
  localparam int VEL_W    = 7;
  localparam int RANGE_W  = 2 * KEY_W + 2 * VEL_W;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;
  localparam int PLAYER_W = 5;
  localparam int SLOT_W   = 6;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ADD_REGION = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NOTE_ON    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_NOTE_OFF   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_STOP_ALL   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERLOAD   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;

  // Decoded kind of an incoming word.
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_NOTE = 2'd1;
  localparam logic [1:0] KIND_NOP  = 2'd2;
  localparam logic [1:0] KIND_STOP = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;        // capture the accepted word and clear per-word results
    logic add_wr;     // store a region, or flag the table as full
    logic walk_step;  // check one region and issue the next table read
    logic pop_step;   // move the newest active player back to the idle stack
    logic load_out;   // load the result registers
  } sva_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;       // decoded kind of the word at the input
    logic       walk_done;  // every stored region has been checked
    logic       ovl_hit;    // a matching region found no idle player
    logic       roll_done;  // every player of this note has been returned
    logic       stop_done;  // the active list is empty
  } sva_stat_t;

endpackage

/* rtl/sva_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, with registered read data.
// ----------------------------------------------------------------------------
module sva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port share one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/sva_datapath.sv */
// ----------------------------------------------------------------------------
// Sampler voice allocator datapath
// Region table, idle stack, active list, their counters and the result
// registers. Each command moves at most one player per cycle.
// ----------------------------------------------------------------------------
module sva_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  sva_pkg::sva_cmd_t                   cmd,
  output sva_pkg::sva_stat_t                  stat,
  input  logic [sva_pkg::REQ_W-1:0]           req_type,
  input  logic [sva_pkg::KEY_W-1:0]           note_key,
  input  logic [sva_pkg::VEL_W-1:0]           velocity,
  input  logic [sva_pkg::KEY_W-1:0]           lo_key,
  input  logic [sva_pkg::KEY_W-1:0]           hi_key,
  input  logic [sva_pkg::VEL_W-1:0]           lo_vel,
  input  logic [sva_pkg::VEL_W-1:0]           hi_vel,
  output logic [sva_pkg::STATUS_W-1:0]        status,
  output logic [sva_pkg::COUNT_W-1:0]         affected_count,
  output logic [sva_pkg::COUNT_W-1:0]         active_total,
  output logic [sva_pkg::PLAYER_W-1:0]        last_player,
  output logic [sva_pkg::SLOT_W-1:0]          region_slot
);

  import sva_pkg::*;

  // Captured word.
  logic [REQ_W-1:0]   req_q;
  logic [KEY_W-1:0]   key_q;
  logic [VEL_W-1:0]   vel_q;
  logic [RANGE_W-1:0] ranges_q;

  // Decoded kind of the word at the input.
  logic [1:0]         kind_dec;

  // Region table and walk.
  logic [RCW-1:0]     region_count;
  logic [RCW-1:0]     rd_idx;
  logic               pend;
  logic               ram_we;
  logic [RIW-1:0]     ram_addr;
  logic [RANGE_W-1:0] ram_rdata;
  logic               match;

  // Player pool.
  logic [PIW-1:0] idle_stack  [PLAYERS];
  logic [PIW-1:0] active_list [PLAYERS];
  logic [PCW-1:0] idle_count;
  logic [PCW-1:0] active_count;
  logic [PCW-1:0] idle_m1;
  logic [PCW-1:0] active_m1;
  logic           pool_full;
  logic           alloc;
  logic           pop;

  // Per-word results.
  logic [PCW-1:0] started;
  logic [PIW-1:0] last_q;
  logic [PCW-1:0] stop_aff;
  logic [RIW-1:0] slot_q;
  logic           ovl;
  logic           table_full;
  logic           is_stop;

  // Decode the word at the input for the controller.
  always_comb begin
    case (req_type)
      REQ_ADD_REGION: kind_dec = KIND_ADD;
      REQ_NOTE_ON:    kind_dec = (velocity != '0) ? KIND_NOTE : KIND_NOP;
      REQ_STOP_ALL:   kind_dec = KIND_STOP;
      default:        kind_dec = KIND_NOP;
    endcase
  end

  assign stat.kind = kind_dec;

  // The table is written at the fill count during an add, else read for the walk.
  assign ram_we   = cmd.add_wr && (region_count < RCW'(REGIONS));
  assign ram_addr = ram_we ? region_count[RIW-1:0] : rd_idx[RIW-1:0];

  sva_ram #(
    .WIDTH (RANGE_W),
    .DEPTH (REGIONS)
  ) u_region_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ranges_q),
    .rdata (ram_rdata)
  );

  // Entries are packed {hi_vel, lo_vel, hi_key, lo_key}, lo_key in the low bits.
  assign match = (key_q >= ram_rdata[KEY_W-1:0]) &&
                 (key_q <= ram_rdata[2*KEY_W-1:KEY_W]) &&
                 (vel_q >= ram_rdata[2*KEY_W+VEL_W-1:2*KEY_W]) &&
                 (vel_q <= ram_rdata[RANGE_W-1:2*KEY_W+VEL_W]);

  assign idle_m1   = idle_count - 1'b1;
  assign active_m1 = active_count - 1'b1;
  assign pool_full = (active_count == PCW'(PLAYERS)) || (idle_count == '0);
  assign alloc     = cmd.walk_step && pend && match && !pool_full;
  assign pop       = cmd.pop_step && (active_count != '0);
  assign is_stop   = (req_q == REQ_STOP_ALL);

  assign stat.walk_done = !pend && (rd_idx == region_count);
  assign stat.ovl_hit   = pend && match && pool_full;
  assign stat.roll_done = (started == '0);
  assign stat.stop_done = (active_count == '0);

  // Idle stack: reset loads player i into entry i; a pop pushes a player back.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PLAYERS; i++) begin
        idle_stack[i] <= PIW'(i);
      end
    end else if (pop) begin
      idle_stack[idle_count[PIW-1:0]] <= active_list[active_m1[PIW-1:0]];
    end
  end

  // Active list: an allocation appends the player from the top of the idle stack.
  always_ff @(posedge clk) begin
    if (alloc) begin
      active_list[active_count[PIW-1:0]] <= idle_stack[idle_m1[PIW-1:0]];
    end
  end

  // Counters, walk position and per-word results.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
      idle_count   <= PCW'(PLAYERS);
      active_count <= '0;
      rd_idx       <= '0;
      pend         <= 1'b0;
      started      <= '0;
      ovl          <= 1'b0;
      table_full   <= 1'b0;
    end else begin
      if (cmd.cap) begin
        req_q      <= req_type;
        key_q      <= note_key;
        vel_q      <= velocity;
        ranges_q   <= {hi_vel, lo_vel, hi_key, lo_key};
        rd_idx     <= '0;
        pend       <= 1'b0;
        started    <= '0;
        last_q     <= '0;
        ovl        <= 1'b0;
        table_full <= 1'b0;
        slot_q     <= '0;
        stop_aff   <= active_count;
      end
      if (cmd.add_wr) begin
        if (ram_we) begin
          slot_q       <= region_count[RIW-1:0];
          region_count <= region_count + 1'b1;
        end else begin
          table_full <= 1'b1;
        end
      end
      if (cmd.walk_step) begin
        if (stat.ovl_hit) begin
          ovl <= 1'b1;
        end
        if (alloc) begin
          idle_count   <= idle_m1;
          active_count <= active_count + 1'b1;
          started      <= started + 1'b1;
          last_q       <= idle_stack[idle_m1[PIW-1:0]];
        end
        // Issue the next table read while the previous entry is checked.
        if (rd_idx < region_count) begin
          rd_idx <= rd_idx + 1'b1;
          pend   <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      if (pop) begin
        active_count <= active_m1;
        idle_count   <= idle_count + 1'b1;
        if (started != '0) begin
          started <= started - 1'b1;
        end
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (ovl) begin
        status <= ST_OVERLOAD;
      end else if (table_full) begin
        status <= ST_TABLE_FULL;
      end else begin
        status <= ST_OK;
      end
      affected_count <= is_stop ? COUNT_W'(stop_aff) : COUNT_W'(started);
      active_total   <= COUNT_W'(active_count);
      last_player    <= ovl ? '0 : PLAYER_W'(last_q);
      region_slot    <= SLOT_W'(slot_q);
    end
  end

endmodule

/* rtl/sva_ctrl.sv */
// ----------------------------------------------------------------------------
// Sampler voice allocator controller
// Sequences one word at a time through add, walk, rollback and stop-all
// steps, and owns both handshakes.
// ----------------------------------------------------------------------------
module sva_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sva_pkg::sva_stat_t  stat,
  output sva_pkg::sva_cmd_t   cmd
);

  import sva_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_NOTE = 3'd2;
  localparam logic [2:0] S_ROLL = 3'd3;
  localparam logic [2:0] S_STOP = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.cap = 1'b1;
          case (stat.kind)
            KIND_ADD:  state_next = S_ADD;
            KIND_NOTE: state_next = S_NOTE;
            KIND_STOP: state_next = S_STOP;
            default:   state_next = S_FIN;
          endcase
        end
      end
      S_ADD: begin
        cmd.add_wr = 1'b1;
        state_next = S_FIN;
      end
      S_NOTE: begin
        if (stat.walk_done) begin
          state_next = S_FIN;
        end else begin
          cmd.walk_step = 1'b1;
          if (stat.ovl_hit) begin
            state_next = S_ROLL;
          end
        end
      end
      S_ROLL: begin
        if (stat.roll_done) begin
          state_next = S_FIN;
        end else begin
          cmd.pop_step = 1'b1;
        end
      end
      S_STOP: begin
        if (stat.stop_done) begin
          state_next = S_FIN;
        end else begin
          cmd.pop_step = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/sampler_voice_allocator.sv */
// A note off or a zero-velocity note on goes straight to the result word; an add region
// writes the table first, and a stop all first returns every active player to the idle stack.
// A note on walks the region table, reading one table entry per cycle; an overload ends
// the walk early and returns each player started for this note to the idle stack.
// One word is in work at a time: no new word is accepted until its result is loaded.
// Reset empties the region table and active list and puts player i in idle stack entry i.
// ----------------------------------------------------------------------------
// Sampler voice allocator
// Stores region key and velocity ranges and assigns players from an idle
// stack to every region a note on matches, all or none.
// ----------------------------------------------------------------------------
module sampler_voice_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sva_pkg::REQ_W-1:0]    req_type,
  input  logic [sva_pkg::KEY_W-1:0]    note_key,
  input  logic [sva_pkg::VEL_W-1:0]    velocity,
  input  logic [sva_pkg::KEY_W-1:0]    lo_key,
  input  logic [sva_pkg::KEY_W-1:0]    hi_key,
  input  logic [sva_pkg::VEL_W-1:0]    lo_vel,
  input  logic [sva_pkg::VEL_W-1:0]    hi_vel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sva_pkg::STATUS_W-1:0] status,
  output logic [sva_pkg::COUNT_W-1:0]  affected_count,
  output logic [sva_pkg::COUNT_W-1:0]  active_total,
  output logic [sva_pkg::PLAYER_W-1:0] last_player,
  output logic [sva_pkg::SLOT_W-1:0]   region_slot
);

  import sva_pkg::*;

  sva_cmd_t  cmd;
  sva_stat_t stat;

  sva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sva_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (req_type),
    .note_key       (note_key),
    .velocity       (velocity),
    .lo_key         (lo_key),
    .hi_key         (hi_key),
    .lo_vel         (lo_vel),
    .hi_vel         (hi_vel),
    .status         (status),
    .affected_count (affected_count),
    .active_total   (active_total),
    .last_player    (last_player),
    .region_slot    (region_slot)
  );

endmodule
